/* src/iop_pkg.sv */
package iop_pkg;

    // Operand and request layout
    localparam int DATA_W              = 64;
    localparam int HALF_W              = DATA_W / 2;
    localparam int MAG_W               = 2 * DATA_W;
    localparam int OP_W                = 3;
    localparam int KIND_W              = 2;
    localparam int DEFAULT_VALUE_WIDTH = 64;

    // Stream widths: input fields packed from a_min up, padded to bytes
    localparam int S_TDATA_W = 392;
    localparam int M_TDATA_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_MOD = 3'd4;

    // Proof kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RANGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONST = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DIV   = 2'd3;

    // Multiplier slots
    localparam int MUL_N   = 5;
    localparam int MUL_LL  = 0;
    localparam int MUL_LH  = 1;
    localparam int MUL_HL  = 2;
    localparam int MUL_HH  = 3;
    localparam int MUL_CST = 4;

    typedef struct packed {
        logic [OP_W-1:0]          req_type;
        logic signed [DATA_W-1:0] a_min;
        logic signed [DATA_W-1:0] a_max;
        logic                     a_bounded;
        logic signed [DATA_W-1:0] b_min;
        logic signed [DATA_W-1:0] b_max;
        logic                     b_bounded;
        logic                     a_is_const;
        logic signed [DATA_W-1:0] a_const;
        logic                     b_is_const;
        logic signed [DATA_W-1:0] b_const;
    } iop_req_t;

endpackage

/* src/iop_mul_fit.sv */
// Signed 64x64 product over two stages (32x32 partial products, then sum),
// with a check that the exact product fits in the signed VALUE_WIDTH range.
module iop_mul_fit
    import iop_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                     aclk,
    input  logic                     pp_en,
    input  logic                     sum_en,
    input  logic signed [DATA_W-1:0] op_a,
    input  logic signed [DATA_W-1:0] op_b,
    output logic                     fits
);

    // Magnitude limit: 2^(VALUE_WIDTH-1)
    localparam logic [MAG_W-1:0] BOUND =
        {{(MAG_W - VALUE_WIDTH){1'b0}}, 1'b1, {(VALUE_WIDTH - 1){1'b0}}};

    logic [DATA_W-1:0]   mag_a;
    logic [DATA_W-1:0]   mag_b;
    logic                neg_next;
    logic [DATA_W-1:0]   pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic                neg_pp_reg;
    logic [MAG_W-1:0]    mag_next;
    logic [MAG_W-1:0]    mag_reg;
    logic                neg_reg;

    // Take magnitudes and result sign
    always_comb begin
        mag_a    = op_a[DATA_W-1] ? (~op_a + 1'b1) : op_a;
        mag_b    = op_b[DATA_W-1] ? (~op_b + 1'b1) : op_b;
        neg_next = op_a[DATA_W-1] ^ op_b[DATA_W-1];
    end

    // Register the four partial products
    always_ff @(posedge aclk) begin
        if (pp_en) begin
            pp00_reg   <= mag_a[HALF_W-1:0]      * mag_b[HALF_W-1:0];
            pp01_reg   <= mag_a[HALF_W-1:0]      * mag_b[DATA_W-1:HALF_W];
            pp10_reg   <= mag_a[DATA_W-1:HALF_W] * mag_b[HALF_W-1:0];
            pp11_reg   <= mag_a[DATA_W-1:HALF_W] * mag_b[DATA_W-1:HALF_W];
            neg_pp_reg <= neg_next;
        end
    end

    // Combine partial products into the full magnitude
    always_comb begin
        mag_next = {{DATA_W{1'b0}}, pp00_reg}
                 + ({{DATA_W{1'b0}}, pp01_reg} << HALF_W)
                 + ({{DATA_W{1'b0}}, pp10_reg} << HALF_W)
                 + {pp11_reg, {DATA_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (sum_en) begin
            mag_reg <= mag_next;
            neg_reg <= neg_pp_reg;
        end
    end

    // Negative products may reach the bound itself
    assign fits = neg_reg ? (mag_reg <= BOUND) : (mag_reg < BOUND);

endmodule

/* src/interval_overflow_prover.sv */
// Overflow prover for signed integer operations over known operand ranges.
// Each item carries an opcode (add, sub, mul, div, mod, other) and the range
// and optional constant value of both operands; the result says whether the
// operation provably cannot overflow or trap and which proof applied (range,
// constant, or division trap). One item is accepted every clock unless the
// output stalls; its result passes through four register stages: input
// register, partial-product stage and sum stage of the split 64x64
// multipliers, then the result register.
// Corner products and the constant product use five multiplier lanes.
// VALUE_WIDTH sets the signed range that results must fit into.
module interval_overflow_prover
    import iop_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // a_min, a_max, a_bounded, b_min, b_max, b_bounded,
    // a_is_const, a_const, b_is_const, b_const
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // proven_safe, proof_kind
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Bounds of the signed VALUE_WIDTH range at operand and sum width
    localparam logic signed [DATA_W-1:0] VMIN =
        {{(DATA_W - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};
    localparam logic signed [DATA_W:0] SUM_MIN =
        {{(DATA_W - VALUE_WIDTH + 2){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};
    localparam logic signed [DATA_W:0] SUM_MAX =
        {{(DATA_W - VALUE_WIDTH + 2){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MINUS_ONE = '1;
    localparam logic signed [DATA_W-1:0] ZERO      = '0;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            both;
        logic            both_const;
        logic            as_range_ok;
        logic            as_const_ok;
        logic            div_ok;
    } iop_flags_t;

    iop_req_t   req_in;
    iop_req_t   s1_reg;
    iop_flags_t flags_next;
    iop_flags_t s2_reg;
    iop_flags_t s3_reg;
    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       rdy1, rdy2, rdy3, rdy4;

    logic signed [DATA_W:0]   as_lo, as_hi, cs;
    logic                     nonzero, min_m1;

    logic signed [DATA_W-1:0] mul_a [MUL_N];
    logic signed [DATA_W-1:0] mul_b [MUL_N];
    logic [MUL_N-1:0]         mul_fit;

    logic [KIND_W-1:0]        kind_next;
    logic [KIND_W-1:0]        kind_reg;
    logic                     no_ovf_reg;

    // Stage handshake: a stage loads when it is empty or draining
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // Unpack the input item
    always_comb begin
        req_in.req_type   = s_tuser;
        req_in.a_min      = s_tdata[63:0];
        req_in.a_max      = s_tdata[127:64];
        req_in.a_bounded  = s_tdata[128];
        req_in.b_min      = s_tdata[192:129];
        req_in.b_max      = s_tdata[256:193];
        req_in.b_bounded  = s_tdata[257];
        req_in.a_is_const = s_tdata[258];
        req_in.a_const    = s_tdata[322:259];
        req_in.b_is_const = s_tdata[323];
        req_in.b_const    = s_tdata[387:324];
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            s1_reg <= req_in;
        end
    end

    // Add/sub corner sums, constant sum and division trap checks
    always_comb begin
        if (s1_reg.req_type == OP_SUB) begin
            as_lo = {s1_reg.a_min[DATA_W-1], s1_reg.a_min}
                  - {s1_reg.b_max[DATA_W-1], s1_reg.b_max};
            as_hi = {s1_reg.a_max[DATA_W-1], s1_reg.a_max}
                  - {s1_reg.b_min[DATA_W-1], s1_reg.b_min};
            cs    = {s1_reg.a_const[DATA_W-1], s1_reg.a_const}
                  - {s1_reg.b_const[DATA_W-1], s1_reg.b_const};
        end else begin
            as_lo = {s1_reg.a_min[DATA_W-1], s1_reg.a_min}
                  + {s1_reg.b_min[DATA_W-1], s1_reg.b_min};
            as_hi = {s1_reg.a_max[DATA_W-1], s1_reg.a_max}
                  + {s1_reg.b_max[DATA_W-1], s1_reg.b_max};
            cs    = {s1_reg.a_const[DATA_W-1], s1_reg.a_const}
                  + {s1_reg.b_const[DATA_W-1], s1_reg.b_const};
        end

        nonzero = (s1_reg.b_min > ZERO) || (s1_reg.b_max < ZERO);
        min_m1  = (s1_reg.a_min <= VMIN) && (VMIN <= s1_reg.a_max)
               && (s1_reg.b_min <= MINUS_ONE) && (MINUS_ONE <= s1_reg.b_max);

        flags_next.op          = s1_reg.req_type;
        flags_next.both        = s1_reg.a_bounded && s1_reg.b_bounded;
        flags_next.both_const  = s1_reg.a_is_const && s1_reg.b_is_const;
        flags_next.as_range_ok = (as_lo >= SUM_MIN) && (as_hi <= SUM_MAX);
        flags_next.as_const_ok = (cs >= SUM_MIN) && (cs <= SUM_MAX);
        flags_next.div_ok      = nonzero && !min_m1;
    end

    // Carry flags alongside the multiplier stages
    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) s2_reg <= flags_next;
        if (rdy3 && v2_reg) s3_reg <= s2_reg;
    end

    // Corner products and constant product
    always_comb begin
        mul_a[MUL_LL]  = s1_reg.a_min;   mul_b[MUL_LL]  = s1_reg.b_min;
        mul_a[MUL_LH]  = s1_reg.a_min;   mul_b[MUL_LH]  = s1_reg.b_max;
        mul_a[MUL_HL]  = s1_reg.a_max;   mul_b[MUL_HL]  = s1_reg.b_min;
        mul_a[MUL_HH]  = s1_reg.a_max;   mul_b[MUL_HH]  = s1_reg.b_max;
        mul_a[MUL_CST] = s1_reg.a_const; mul_b[MUL_CST] = s1_reg.b_const;
    end

    for (genvar g = 0; g < MUL_N; g++) begin : g_mul
        iop_mul_fit #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_mul (
            .aclk   (aclk),
            .pp_en  (rdy2 && v1_reg),
            .sum_en (rdy3 && v2_reg),
            .op_a   (mul_a[g]),
            .op_b   (mul_b[g]),
            .fits   (mul_fit[g])
        );
    end

    // Pick the proof; all four corners fitting bounds the least and greatest
    always_comb begin
        logic range_ok;
        logic const_ok;
        range_ok  = (s3_reg.op == OP_MUL) ? (&mul_fit[MUL_HH:MUL_LL])
                                          : s3_reg.as_range_ok;
        const_ok  = (s3_reg.op == OP_MUL) ? mul_fit[MUL_CST] : s3_reg.as_const_ok;
        kind_next = KIND_NONE;
        unique case (s3_reg.op) inside
            OP_ADD, OP_SUB, OP_MUL: begin
                if (s3_reg.both && range_ok) begin
                    kind_next = KIND_RANGE;
                end else if (s3_reg.both_const && const_ok) begin
                    kind_next = KIND_CONST;
                end
            end
            OP_DIV, OP_MOD: begin
                if (s3_reg.both && s3_reg.div_ok) begin
                    kind_next = KIND_DIV;
                end
            end
            default: kind_next = KIND_NONE;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            kind_reg   <= kind_next;
            no_ovf_reg <= (kind_next != KIND_NONE);
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(M_TDATA_W - KIND_W - 1){1'b0}}, kind_reg, no_ovf_reg};

`ifndef SYNTHESIS
    // The flag and the proof kind agree on every delivered item
    a_flag_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != KIND_NONE)))
        else $error("proven_safe disagrees with proof_kind");

    // An item leaving the last carry stage lands in the result register
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && rdy4) |=> m_tvalid)
        else $error("item lost between stage three and output");

    // A division trap proof only comes from div or mod
    a_div_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && kind_next == KIND_DIV) |-> (s3_reg.op == OP_DIV || s3_reg.op == OP_MOD))
        else $error("division proof on a non-division opcode");
`endif

endmodule

/* tb/interval_overflow_prover_tb.sv */
module interval_overflow_prover_tb;
    import iop_pkg::*;

    localparam int VALUE_W = DEFAULT_VALUE_WIDTH;
    localparam int RANDOM_REQS = 850;

    localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    // largest magnitude whose square still fits in int64
    localparam logic signed [63:0] MUL_EDGE = 64'sd3037000499;

    localparam logic signed [127:0] VAL_MIN = -(128'sd1 <<< (VALUE_W - 1));
    localparam logic signed [127:0] VAL_MAX = (128'sd1 <<< (VALUE_W - 1)) - 128'sd1;
    localparam logic signed [63:0]  DIV_MIN = VAL_MIN[63:0];

    typedef struct packed {
        logic              no_ovf;
        logic [KIND_W-1:0] kind;
    } proof_t;

    typedef struct {
        iop_req_t req;
        bit       drain_first;
    } req_slot_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    iop_req_t  cur_req = '0;
    logic      in_fire = 1'b0;
    req_slot_t req_backlog[$];
    proof_t    proofs_due[$];
    int        reqs_taken = 0;
    int        reqs_total = 0;
    int        proof_errors = 0;
    int        send_idle_pct = 27;
    int        recv_idle_pct = 45;

    interval_overflow_prover i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [127:0] widen(input logic [63:0] v);
        return {{64{v[63]}}, v};
    endfunction

    // Work out which proof, if any, the block must report for one request
    function automatic proof_t predict_proof(input iop_req_t r);
        logic signed [127:0] amin, amax, bmin, bmax, ca, cb, cv, lo, hi;
        logic signed [127:0] corner[4];
        logic signed [63:0]  nmin, nmax, dmin, dmax;
        logic                both, range_ok, const_ok, nonzero, min_by_m1;
        proof_t              p;
        amin = widen(r.a_min);
        amax = widen(r.a_max);
        bmin = widen(r.b_min);
        bmax = widen(r.b_max);
        ca = widen(r.a_const);
        cb = widen(r.b_const);
        both = r.a_bounded && r.b_bounded;
        p.kind = KIND_NONE;
        case (r.req_type) inside
            OP_ADD, OP_SUB, OP_MUL: begin
                if (r.req_type == OP_ADD) begin
                    lo = amin + bmin;
                    hi = amax + bmax;
                    cv = ca + cb;
                end else if (r.req_type == OP_SUB) begin
                    lo = amin - bmax;
                    hi = amax - bmin;
                    cv = ca - cb;
                end else begin
                    // take least and greatest of the four corner products
                    corner[0] = amin * bmin;
                    corner[1] = amin * bmax;
                    corner[2] = amax * bmin;
                    corner[3] = amax * bmax;
                    lo = corner[0];
                    hi = corner[0];
                    for (int k = 1; k < 4; k++) begin
                        if (corner[k] > hi) hi = corner[k];
                        if (corner[k] < lo) lo = corner[k];
                    end
                    cv = ca * cb;
                end
                range_ok = both && lo >= VAL_MIN && hi <= VAL_MAX;
                const_ok = r.a_is_const && r.b_is_const && cv >= VAL_MIN && cv <= VAL_MAX;
                if (range_ok) p.kind = KIND_RANGE;
                else if (const_ok) p.kind = KIND_CONST;
            end
            OP_DIV, OP_MOD: begin
                nmin = r.a_min;
                nmax = r.a_max;
                dmin = r.b_min;
                dmax = r.b_max;
                nonzero = dmin > 64'sd0 || dmax < 64'sd0;
                min_by_m1 = nmin <= DIV_MIN && DIV_MIN <= nmax &&
                            dmin <= -64'sd1 && -64'sd1 <= dmax;
                if (both && nonzero && !min_by_m1) p.kind = KIND_DIV;
            end
            default: ;
        endcase
        p.no_ovf = (p.kind != KIND_NONE);
        return p;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_req(input iop_req_t r);
        return {{(S_TDATA_W - 388){1'b0}}, r.b_const, r.b_is_const, r.a_const,
                r.a_is_const, r.b_bounded, r.b_max, r.b_min, r.a_bounded,
                r.a_max, r.a_min};
    endfunction

    function automatic iop_req_t make_req(
        input logic [OP_W-1:0] op,
        input logic [63:0] amin, input logic [63:0] amax, input logic abnd,
        input logic [63:0] bmin, input logic [63:0] bmax, input logic bbnd,
        input logic ac_en, input logic [63:0] ac,
        input logic bc_en, input logic [63:0] bc);
        iop_req_t r;
        r.req_type   = op;
        r.a_min      = amin;
        r.a_max      = amax;
        r.a_bounded  = abnd;
        r.b_min      = bmin;
        r.b_max      = bmax;
        r.b_bounded  = bbnd;
        r.a_is_const = ac_en;
        r.a_const    = ac;
        r.b_is_const = bc_en;
        r.b_const    = bc;
        return r;
    endfunction

    // Draw a value biased toward the overflow boundaries
    function automatic logic signed [63:0] pick_value();
        logic signed [63:0] v;
        case ($urandom_range(0, 6))
            0: v = {32'd0, $urandom_range(0, 200)} - 64'sd100;
            1: v = {$urandom, $urandom};
            2: begin
                case ($urandom_range(0, 4))
                    0: v = I64_MIN;
                    1: v = I64_MAX;
                    2: v = 64'sd0;
                    3: v = -64'sd1;
                    default: v = 64'sd1;
                endcase
            end
            3: v = I64_MAX - {32'd0, $urandom_range(0, 50)};
            4: v = I64_MIN + {32'd0, $urandom_range(0, 50)};
            5: begin
                v = (64'sd1 <<< $urandom_range(0, 62)) + {32'd0, $urandom_range(0, 4)} - 64'sd2;
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                v = MUL_EDGE + {32'd0, $urandom_range(0, 6)} - 64'sd3;
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic iop_req_t random_req();
        iop_req_t           r;
        logic signed [63:0] x, y, t;
        int                 n;
        n = $urandom_range(0, 15);
        r.req_type = (n < 15) ? OP_W'(n % 5) : OP_W'($urandom_range(5, 7));
        // operand ranges, mostly ordered, sometimes a single point
        x = pick_value();
        y = ($urandom_range(0, 3) == 0) ? x : pick_value();
        if (x > y && $urandom_range(0, 7) != 0) begin
            t = x; x = y; y = t;
        end
        r.a_min = x;
        r.a_max = y;
        x = pick_value();
        y = ($urandom_range(0, 3) == 0) ? x : pick_value();
        if (x > y && $urandom_range(0, 7) != 0) begin
            t = x; x = y; y = t;
        end
        r.b_min = x;
        r.b_max = y;
        r.a_bounded  = ($urandom_range(0, 9) != 0);
        r.b_bounded  = ($urandom_range(0, 9) != 0);
        r.a_is_const = ($urandom_range(0, 2) != 0);
        r.b_is_const = ($urandom_range(0, 2) != 0);
        r.a_const = ($urandom_range(0, 2) == 0) ? pick_value() : r.a_min;
        r.b_const = ($urandom_range(0, 2) == 0) ? pick_value() : r.b_max;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        proof_errors++;
    endtask

    // Drive requests from the backlog; hold each until accepted
    always @(negedge aclk) begin
        req_slot_t slot;
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (req_backlog.size() > 0 && req_backlog[0].drain_first && proofs_due.size() > 0) begin
                s_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                slot = req_backlog.pop_front();
                cur_req  <= slot.req;
                s_tdata  <= pack_req(slot.req);
                s_tuser  <= slot.req.req_type;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict on each accepted item, check each accepted result
    always @(posedge aclk) begin
        proof_t got, want;
        in_fire <= s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got.no_ovf = m_tdata[0];
            got.kind   = m_tdata[2:1];
            if (proofs_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = proofs_due.pop_front();
                if (got.no_ovf != want.no_ovf)
                    report_mismatch($sformatf("proven_safe got %0b want %0b",
                                              got.no_ovf, want.no_ovf));
                if (got.kind != want.kind)
                    report_mismatch($sformatf("proof_kind got %0d want %0d",
                                              got.kind, want.kind));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            proofs_due.push_back(predict_proof(cur_req));
            reqs_taken++;
        end
    end

    initial begin
        req_slot_t slot;
        // directed: boundaries of each operation and the special cases
        slot.drain_first = 1'b0;
        slot.req = make_req(OP_ADD, 0, 10, 1, 0, 10, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_ADD, 0, I64_MAX, 1, 0, 1, 1, 1, 1, 1, 2);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_ADD, I64_MAX, I64_MAX, 1, 1, 1, 1, 1, I64_MAX, 1, 1);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_ADD, I64_MIN, I64_MIN, 0, -1, -1, 1, 1, I64_MIN, 1, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_SUB, I64_MIN, 0, 1, 0, 1, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_SUB, 0, 0, 1, I64_MIN, I64_MIN, 1, 1, -1, 1, I64_MIN);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_SUB, -5, 5, 1, -5, 5, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_MUL, -MUL_EDGE, MUL_EDGE, 1, -MUL_EDGE, MUL_EDGE, 1,
                            0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_MUL, 0, MUL_EDGE + 1, 1, 0, MUL_EDGE + 1, 1,
                            1, -1, 1, I64_MIN);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_MUL, I64_MIN, I64_MAX, 0, I64_MIN, I64_MAX, 0,
                            1, I64_MIN, 1, 1);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_MUL, I64_MIN, I64_MAX, 1, I64_MIN, I64_MAX, 1, 1, 0, 1, 0);
        req_backlog.push_back(slot);
        // inverted ranges are taken literally
        slot.req = make_req(OP_ADD, 10, -10, 1, 5, -5, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_MUL, 5, -5, 1, 3, -3, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        // division trap cases; the first waits for an empty pipeline
        slot.drain_first = 1'b1;
        slot.req = make_req(OP_DIV, I64_MIN, I64_MAX, 1, 1, 10, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.drain_first = 1'b0;
        slot.req = make_req(OP_DIV, 0, 100, 1, -5, 5, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_DIV, I64_MIN, 0, 1, -1, -1, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_DIV, I64_MIN + 1, I64_MAX, 1, -1, -1, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_DIV, 0, 100, 1, 1, 10, 0, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_MOD, I64_MIN, 0, 1, -10, -1, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_MOD, I64_MIN, 0, 1, -10, -2, 1, 0, 0, 0, 0);
        req_backlog.push_back(slot);
        slot.req = make_req(OP_MOD, 0, 100, 1, 0, 0, 1, 1, 5, 1, 0);
        req_backlog.push_back(slot);
        // opcodes without a proof
        for (int op = 5; op < 8; op++) begin
            slot.req = make_req(OP_W'(op), 0, 1, 1, 1, 2, 1, 1, 1, 1, 1);
            req_backlog.push_back(slot);
        end
        slot.req = '1;
        req_backlog.push_back(slot);
        slot.req = '0;
        req_backlog.push_back(slot);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            slot.req = random_req();
            slot.drain_first = (i == 100) || (i == 500) || ($urandom_range(0, 199) == 0);
            req_backlog.push_back(slot);
        end
        reqs_total = req_backlog.size();

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // swap the idle pattern, then run without idling
        while (reqs_taken < reqs_total / 3) @(posedge aclk);
        send_idle_pct = 45;
        recv_idle_pct = 27;
        while (reqs_taken < 2 * reqs_total / 3) @(posedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // drain the pipeline, then wait for stray results
        while (reqs_taken < reqs_total || proofs_due.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (proof_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
src/iop_pkg.sv
src/iop_mul_fit.sv
src/interval_overflow_prover.sv
tb/interval_overflow_prover_tb.sv
